### rtl/gamepad_report_parser_core_macros.svh
// ----------------------------------------------------------------------------
// Gamepad report parser assertion macros
// Shared assertion forms for the gamepad report parser, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_REPORT_PARSER_CORE_MACROS_SVH
`define GAMEPAD_REPORT_PARSER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GPRP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GPRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/gprp_pkg.sv
// ----------------------------------------------------------------------------
// Gamepad report parser package
// Constants, codes and transaction types shared by the parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gprp_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h00;
  localparam logic [7:0] HDR_SECOND = 8'h14;
  localparam logic [3:0] POS_MAX    = 4'd15;
  localparam logic [3:0] MIN_LAST   = 4'd14;
  localparam logic [3:0] CAP_FIRST  = 4'd2;
  localparam logic [3:0] CAP_LAST   = 4'd13;
  localparam int         CAP_COUNT  = 12;

  localparam logic [6:0] DEADZONE_RESET = 7'd8;
  localparam logic [6:0] DEADZONE_FULL  = 7'd127;
  localparam logic [7:0] SCALE_POS      = 8'd127;
  localparam logic [7:0] SCALE_NEG      = 8'd128;
  localparam logic [7:0] AXIS_MIN       = 8'h80;
  localparam logic [7:0] AXIS_MAX       = 8'h7F;

  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEPS   = 8;

  localparam logic [3:0] PAD_N  = 4'd1;
  localparam logic [3:0] PAD_NE = 4'd2;
  localparam logic [3:0] PAD_E  = 4'd3;
  localparam logic [3:0] PAD_SE = 4'd4;
  localparam logic [3:0] PAD_S  = 4'd5;
  localparam logic [3:0] PAD_SW = 4'd6;
  localparam logic [3:0] PAD_W  = 4'd7;
  localparam logic [3:0] PAD_NW = 4'd8;

  typedef struct packed {
    logic [15:0] buttons;
    logic [7:0]  trig_left;
    logic [7:0]  trig_right;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic        pad_up;
    logic        pad_down;
    logic        pad_left;
    logic        pad_right;
  } report_t;

endpackage

### rtl/gprp_front.sv
// ----------------------------------------------------------------------------
// Gamepad report parser front end
// Accepts report bytes, checks the header and length, captures the fields
// and pushes one decoded transaction per valid report into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gprp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output gprp_pkg::report_t push_data_o
);

  logic [3:0] pos_q, pos_d;
  logic       hdr_ok_q, hdr_ok_d;
  logic [7:0] cap_q [gprp_pkg::CAP_COUNT];
  logic [3:0] cap_idx;
  logic       accept;
  logic [3:0] pad;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & push_ready_i;
  assign cap_idx    = pos_q - gprp_pkg::CAP_FIRST;

  always_comb begin
    pos_d    = pos_q;
    hdr_ok_d = hdr_ok_q;
    if (accept) begin
      if (pos_q == 4'd0 && data_byte_i != gprp_pkg::HDR_FIRST) begin
        hdr_ok_d = 1'b0;
      end
      if (pos_q == 4'd1 && data_byte_i != gprp_pkg::HDR_SECOND) begin
        hdr_ok_d = 1'b0;
      end
      if (pos_q != gprp_pkg::POS_MAX) begin
        pos_d = pos_q + 4'd1;
      end
      if (last_byte_i) begin
        pos_d    = '0;
        hdr_ok_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      hdr_ok_q <= 1'b1;
    end else begin
      pos_q    <= pos_d;
      hdr_ok_q <= hdr_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pos_q >= gprp_pkg::CAP_FIRST && pos_q <= gprp_pkg::CAP_LAST) begin
      cap_q[cap_idx] <= data_byte_i;
    end
  end

  // A report that ends here has at least fifteen bytes, so neither header
  // byte is the current one and the stored header flag is final.
  assign push_valid_o = accept & last_byte_i & hdr_ok_q & (pos_q >= gprp_pkg::MIN_LAST);

  assign pad = cap_q[0][3:0];

  always_comb begin
    push_data_o.buttons    = {cap_q[1], cap_q[0]};
    push_data_o.trig_left  = cap_q[2];
    push_data_o.trig_right = cap_q[3];
    push_data_o.left_x     = cap_q[5];
    push_data_o.left_y     = (cap_q[7] == gprp_pkg::AXIS_MIN) ? gprp_pkg::AXIS_MAX
                                                              : 8'(-cap_q[7]);
    push_data_o.right_x    = cap_q[9];
    push_data_o.right_y    = (cap_q[11] == gprp_pkg::AXIS_MIN) ? gprp_pkg::AXIS_MAX
                                                               : 8'(-cap_q[11]);
    push_data_o.pad_up    = (pad == gprp_pkg::PAD_N) || (pad == gprp_pkg::PAD_NE) ||
                            (pad == gprp_pkg::PAD_NW);
    push_data_o.pad_down  = (pad == gprp_pkg::PAD_SE) || (pad == gprp_pkg::PAD_S) ||
                            (pad == gprp_pkg::PAD_SW);
    push_data_o.pad_left  = (pad == gprp_pkg::PAD_SW) || (pad == gprp_pkg::PAD_W) ||
                            (pad == gprp_pkg::PAD_NW);
    push_data_o.pad_right = (pad == gprp_pkg::PAD_NE) || (pad == gprp_pkg::PAD_E) ||
                            (pad == gprp_pkg::PAD_SE);
  end

endmodule

### rtl/gprp_queue.sv
// ----------------------------------------------------------------------------
// Gamepad report parser queue
// Small first-in first-out buffer of decoded reports between the front end
// and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gprp_queue #(
  parameter int Depth = gprp_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  gprp_pkg::report_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output gprp_pkg::report_t pop_data_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  gprp_pkg::report_t mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          push, pop;

  assign push_ready_o = (count_q != CW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/gprp_axis.sv
// ----------------------------------------------------------------------------
// Gamepad report parser stick axis lane
// Applies the deadzone to one signed stick value and rescales the rest with
// a restoring divider that yields one quotient bit per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gprp_axis (
  input  logic              clk_i,
  input  logic              load_i,
  input  logic              step_i,
  input  logic signed [7:0] axis_i,
  input  logic [6:0]        deadzone_i,
  output logic [7:0]        result_o
);

  logic [7:0]  rem_q, num_lo_q, den_q, quo_q;
  logic        neg_q;
  logic        vneg, below, full;
  logic [7:0]  mag, dz8, diff;
  logic [14:0] num;
  logic [7:0]  den;
  logic [8:0]  trial;
  logic        fits;

  assign vneg  = axis_i[7];
  assign mag   = vneg ? 8'(-axis_i) : axis_i;
  assign dz8   = {1'b0, deadzone_i};
  assign below = (mag < dz8);
  assign diff  = mag - dz8;
  assign full  = !vneg && (deadzone_i == gprp_pkg::DEADZONE_FULL);

  always_comb begin
    if (below) begin
      num = '0;
      den = 8'd1;
    end else if (full) begin
      num = 15'(gprp_pkg::SCALE_POS);
      den = 8'd1;
    end else if (vneg) begin
      num = {diff, 7'd0};
      den = gprp_pkg::SCALE_NEG - dz8;
    end else begin
      num = {diff, 7'd0} - {7'd0, diff};
      den = gprp_pkg::SCALE_POS - dz8;
    end
  end

  assign trial = {rem_q, num_lo_q[7]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q    <= {1'b0, num[14:8]};
      num_lo_q <= num[7:0];
      den_q    <= den;
      quo_q    <= '0;
      neg_q    <= vneg;
    end else if (step_i) begin
      rem_q    <= fits ? 8'(trial - {1'b0, den_q}) : trial[7:0];
      num_lo_q <= {num_lo_q[6:0], 1'b0};
      quo_q    <= {quo_q[6:0], fits};
    end
  end

  assign result_o = neg_q ? 8'(-quo_q) : quo_q;

endmodule

### rtl/gprp_back.sv
// ----------------------------------------------------------------------------
// Gamepad report parser back end
// Takes decoded reports from the queue, shapes the four stick axes in
// parallel lanes and holds the finished result in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gprp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [6:0]        deadzone_i,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  gprp_pkg::report_t pop_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gprp_pkg::report_t out_data_o
);

  localparam int StepW = $clog2(gprp_pkg::DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } back_state_e;

  back_state_e       state_q, state_d;
  logic [StepW-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  gprp_pkg::report_t job_q, out_q, shaped;
  logic              load, step, out_free, out_load;
  logic [7:0]        lx, ly, rx, ry;

  assign out_free    = !out_valid_q || out_ready_i;
  assign pop_ready_o = (state_q == ST_IDLE);
  assign load        = pop_valid_i && (state_q == ST_IDLE);
  assign step        = (state_q == ST_RUN);
  assign out_load    = (state_q == ST_DONE) && out_free;

  gprp_axis u_lx (
    .clk_i, .load_i(load), .step_i(step), .axis_i(pop_data_i.left_x),
    .deadzone_i, .result_o(lx)
  );
  gprp_axis u_ly (
    .clk_i, .load_i(load), .step_i(step), .axis_i(pop_data_i.left_y),
    .deadzone_i, .result_o(ly)
  );
  gprp_axis u_rx (
    .clk_i, .load_i(load), .step_i(step), .axis_i(pop_data_i.right_x),
    .deadzone_i, .result_o(rx)
  );
  gprp_axis u_ry (
    .clk_i, .load_i(load), .step_i(step), .axis_i(pop_data_i.right_y),
    .deadzone_i, .result_o(ry)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          state_d = ST_RUN;
          cnt_d   = '0;
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == StepW'(gprp_pkg::DIV_STEPS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    shaped         = job_q;
    shaped.left_x  = lx;
    shaped.left_y  = ly;
    shaped.right_x = rx;
    shaped.right_y = ry;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= pop_data_i;
    end
    if (out_load) begin
      out_q <= shaped;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/gamepad_report_parser_core.sv
// Gamepad report parser.
// Report bytes enter on the input channel (in_valid_i, in_ready_o, data_byte_i,
// last_byte_i), one per cycle while in_ready_o is high. The transaction that
// carries last_byte_i ends the report; a report of at least fifteen bytes whose
// header is 0x00, 0x14 gives one result transaction on the output channel
// (out_valid_o, out_ready_i and the decoded fields). Other reports give nothing.
// The deadzone register is written through cfg_valid_i, cfg_ready_o and
// cfg_deadzone_i, and must only change while the parser is idle.
// The four stick dividers run side by side, eight steps of one quotient bit
// each, and the back end finishes one report before the next valid report can
// have fully arrived, so while the receiver keeps up, bytes are accepted at one
// per cycle indefinitely.
// A queue of QueueDepth reports and the output register decouple the input
// from a stalled receiver; once both are full, in_ready_o drops.
// Reset returns the byte position to zero, sets the header flag, empties the
// queue, clears the output valid and returns the deadzone to eight.
// ----------------------------------------------------------------------------
// Gamepad report parser top level
// Joins the front end, the report queue and the back end, and holds the
// deadzone register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "gamepad_report_parser_core_macros.svh"

module gamepad_report_parser_core #(
  parameter int QueueDepth = gprp_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [6:0]        cfg_deadzone_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       buttons_o,
  output logic [7:0]        trig_left_o,
  output logic [7:0]        trig_right_o,
  output logic signed [7:0] left_x_o,
  output logic signed [7:0] left_y_o,
  output logic signed [7:0] right_x_o,
  output logic signed [7:0] right_y_o,
  output logic              pad_up_o,
  output logic              pad_down_o,
  output logic              pad_left_o,
  output logic              pad_right_o
);

  logic [6:0]        deadzone_q;
  logic              push_valid, push_ready, pop_valid, pop_ready;
  gprp_pkg::report_t push_data, pop_data, out_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q <= gprp_pkg::DEADZONE_RESET;
    end else if (cfg_valid_i) begin
      deadzone_q <= cfg_deadzone_i;
    end
  end

  gprp_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .last_byte_i,
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  gprp_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  gprp_back u_back (
    .clk_i,
    .rst_ni,
    .deadzone_i (deadzone_q),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_data_i (pop_data),
    .out_valid_o,
    .out_ready_i,
    .out_data_o (out_data)
  );

  assign buttons_o    = out_data.buttons;
  assign trig_left_o  = out_data.trig_left;
  assign trig_right_o = out_data.trig_right;
  assign left_x_o     = out_data.left_x;
  assign left_y_o     = out_data.left_y;
  assign right_x_o    = out_data.right_x;
  assign right_y_o    = out_data.right_y;
  assign pad_up_o     = out_data.pad_up;
  assign pad_down_o   = out_data.pad_down;
  assign pad_left_o   = out_data.pad_left;
  assign pad_right_o  = out_data.pad_right;

  // A report enters the queue only on the transaction that ends it.
  `GPRP_ASSERT_SAME(a_push_on_last, push_valid, in_valid_i && in_ready_o && last_byte_i,
    "report pushed without an accepted final byte")

  // A full queue always has a report for the back end.
  `GPRP_ASSERT_SAME(a_full_not_empty, !push_ready, pop_valid,
    "queue reports full and empty at once")

  // The direction flags decode one nibble, so opposite directions never pair.
  `GPRP_ASSERT_SAME(a_pad_exclusive, out_valid_o,
    !(pad_up_o && pad_down_o) && !(pad_left_o && pad_right_o),
    "opposite pad directions set together")

endmodule

### test/gamepad_report_parser_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad report parser result checker
// Follows the configuration, byte and result channels. It takes every
// accepted report byte, builds an expected report for each valid report and
// compares each accepted result with the oldest expected report one field at
// a time. Failures and reports still awaited are counted for the testbench top.
// ----------------------------------------------------------------------------

module gamepad_report_parser_core_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [6:0]        cfg_deadzone_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  gprp_pkg::report_t result_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam int ShownMismatches = 10;

  int                deadzone;
  int                byte_pos;
  logic              header_match;
  logic [7:0]        report_bytes [gprp_pkg::CAP_FIRST:gprp_pkg::CAP_LAST];
  gprp_pkg::report_t expected_reports [$];
  int                mismatches;
  int                results_seen;

  assign fail_count_o = mismatches;

  function automatic logic [7:0] shape_stick(input logic [7:0] raw, input logic negate,
                                             input int dz);
    int v;
    int mag;
    int r;
    v = int'($signed(raw));
    if (negate) begin
      v = (v == -128) ? 127 : -v;
    end
    mag = (v < 0) ? -v : v;
    if (mag < dz) begin
      r = 0;
    end else if (v > 0) begin
      r = (dz >= 127) ? 127 : ((v - dz) * 127) / (127 - dz);
    end else begin
      r = ((v + dz) * 128) / (128 - dz);
    end
    return r[7:0];
  endfunction

  function automatic gprp_pkg::report_t decode_report();
    gprp_pkg::report_t r;
    logic [3:0]        pad;
    pad          = report_bytes[2][3:0];
    r.buttons    = {report_bytes[3], report_bytes[2]};
    r.trig_left  = report_bytes[4];
    r.trig_right = report_bytes[5];
    r.left_x     = shape_stick(report_bytes[7], 1'b0, deadzone);
    r.left_y     = shape_stick(report_bytes[9], 1'b1, deadzone);
    r.right_x    = shape_stick(report_bytes[11], 1'b0, deadzone);
    r.right_y    = shape_stick(report_bytes[13], 1'b1, deadzone);
    r.pad_up     = (pad == gprp_pkg::PAD_N) || (pad == gprp_pkg::PAD_NE) ||
                   (pad == gprp_pkg::PAD_NW);
    r.pad_down   = (pad == gprp_pkg::PAD_SE) || (pad == gprp_pkg::PAD_S) ||
                   (pad == gprp_pkg::PAD_SW);
    r.pad_left   = (pad == gprp_pkg::PAD_SW) || (pad == gprp_pkg::PAD_W) ||
                   (pad == gprp_pkg::PAD_NW);
    r.pad_right  = (pad == gprp_pkg::PAD_NE) || (pad == gprp_pkg::PAD_E) ||
                   (pad == gprp_pkg::PAD_SE);
    return r;
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic last);
    int p;
    p = byte_pos;
    if (p == 0 && b != gprp_pkg::HDR_FIRST) begin
      header_match = 1'b0;
    end
    if (p == 1 && b != gprp_pkg::HDR_SECOND) begin
      header_match = 1'b0;
    end
    if (p >= gprp_pkg::CAP_FIRST && p <= gprp_pkg::CAP_LAST) begin
      report_bytes[p] = b;
    end
    if (p < gprp_pkg::POS_MAX) begin
      byte_pos = p + 1;
    end
    if (last) begin
      if (header_match && p >= gprp_pkg::MIN_LAST) begin
        expected_reports.push_back(decode_report());
      end
      byte_pos     = 0;
      header_match = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= ShownMismatches) begin
        $display("result %0d, %s: expected %0h, got %0h", results_seen, name, want, got);
      end
    end
  endtask

  task automatic check_result(input gprp_pkg::report_t got);
    gprp_pkg::report_t want;
    if (expected_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= ShownMismatches) begin
        $display("result %0d arrived with no report awaited", results_seen);
      end
    end else begin
      want = expected_reports.pop_front();
      check_field("buttons", got.buttons, want.buttons);
      check_field("trig_left", 16'(got.trig_left), 16'(want.trig_left));
      check_field("trig_right", 16'(got.trig_right), 16'(want.trig_right));
      check_field("left_x", 16'(got.left_x), 16'(want.left_x));
      check_field("left_y", 16'(got.left_y), 16'(want.left_y));
      check_field("right_x", 16'(got.right_x), 16'(want.right_x));
      check_field("right_y", 16'(got.right_y), 16'(want.right_y));
      check_field("pad_up", 16'(got.pad_up), 16'(want.pad_up));
      check_field("pad_down", 16'(got.pad_down), 16'(want.pad_down));
      check_field("pad_left", 16'(got.pad_left), 16'(want.pad_left));
      check_field("pad_right", 16'(got.pad_right), 16'(want.pad_right));
    end
    results_seen++;
  endtask

  initial begin
    mismatches   = 0;
    results_seen = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone     = int'(gprp_pkg::DEADZONE_RESET);
      byte_pos     = 0;
      header_match = 1'b1;
      for (int i = gprp_pkg::CAP_FIRST; i <= gprp_pkg::CAP_LAST; i++) begin
        report_bytes[i] = 8'h00;
      end
      expected_reports.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        deadzone = int'(cfg_deadzone_i);
      end
      if (out_valid_i && out_ready_i) begin
        check_result(result_i);
      end
      if (in_valid_i && in_ready_i) begin
        take_byte(data_byte_i, last_byte_i);
      end
    end
    pending_o <= expected_reports.size();
  end

endmodule

### test/gamepad_report_parser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad report parser testbench
// Sends directed and random gamepad reports, mostly well formed with varied
// stick values and some with bad headers, short lengths or noise, under a
// range of deadzone settings. Both channels idle at random, and the receiver
// once holds off long enough to fill the parser. The checker decides.
// ----------------------------------------------------------------------------

module gamepad_report_parser_core_tb;

  localparam int IdleCycles  = 20;
  localparam int HoldCycles  = 300;
  localparam int DrainLimit  = 5000;
  localparam int PhaseBytes  = 260;
  localparam int PhaseCount  = 7;

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_deadzone_i = gprp_pkg::DEADZONE_RESET;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i    = 8'h00;
  logic        last_byte_i    = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [15:0] buttons_o;
  logic [7:0]  trig_left_o;
  logic [7:0]  trig_right_o;
  logic [7:0]  left_x_o;
  logic [7:0]  left_y_o;
  logic [7:0]  right_x_o;
  logic [7:0]  right_y_o;
  logic        pad_up_o;
  logic        pad_down_o;
  logic        pad_left_o;
  logic        pad_right_o;

  int   fail_count;
  int   pending;
  logic quiet    = 1'b0;
  logic hold_req = 1'b0;
  int   cur_dz   = int'(gprp_pkg::DEADZONE_RESET);
  int   tx_rate  = 0;
  int   bytes_sent;

  gamepad_report_parser_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_deadzone_i (cfg_deadzone_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .buttons_o      (buttons_o),
    .trig_left_o    (trig_left_o),
    .trig_right_o   (trig_right_o),
    .left_x_o       (left_x_o),
    .left_y_o       (left_y_o),
    .right_x_o      (right_x_o),
    .right_y_o      (right_y_o),
    .pad_up_o       (pad_up_o),
    .pad_down_o     (pad_down_o),
    .pad_left_o     (pad_left_o),
    .pad_right_o    (pad_right_o)
  );

  gamepad_report_parser_core_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_deadzone_i(cfg_deadzone_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_i      ({buttons_o, trig_left_o, trig_right_o, left_x_o, left_y_o,
                     right_x_o, right_y_o, pad_up_o, pad_down_o, pad_left_o,
                     pad_right_o}),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("gamepad_report_parser_core_tb failed");
    $finish;
  end

  // The receiver stalls in short bursts at a rate that changes from stretch to
  // stretch, and once holds off for a long time when asked.
  initial begin : result_sink
    int gap_left;
    int hold_left;
    int rate;
    int span;
    logic hold_done;
    gap_left  = 0;
    hold_left = 0;
    rate      = 0;
    span      = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (span == 0) begin
        span = $urandom_range(20, 120);
        rate = $urandom_range(0, 3);
      end
      span--;
      if (hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (gap_left > 0 && !quiet) begin
        out_ready_i <= 1'b0;
        gap_left--;
      end else begin
        out_ready_i <= 1'b1;
        gap_left = 0;
        if (!quiet && rate != 0 && $urandom_range(0, 7) < rate) begin
          gap_left = $urandom_range(1, 7);
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!quiet && tx_rate != 0 && $urandom_range(0, 7) < tx_rate) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_report(input logic [7:0] bytes [$]);
    foreach (bytes[i]) begin
      send_byte(bytes[i], i == bytes.size() - 1);
    end
  endtask

  function automatic logic [7:0] pick_axis(input int dz);
    int v;
    case ($urandom_range(0, 5))
      0:       v = -128;
      1:       v = 127;
      2:       v = dz + int'($urandom_range(0, 2)) - 1;
      3:       v = -dz + int'($urandom_range(0, 2)) - 1;
      default: v = int'($urandom_range(0, 255));
    endcase
    return v[7:0];
  endfunction

  task automatic send_random_report();
    logic [7:0] bytes [$];
    int kind;
    int len;
    logic [7:0] b;
    tx_rate = $urandom_range(0, 3);
    kind    = $urandom_range(0, 9);
    if (kind == 9) begin
      len = $urandom_range(1, 20);
      for (int i = 0; i < len; i++) begin
        send_byte(8'($urandom_range(0, 255)),
                  (i == len - 1) || ($urandom_range(0, 3) == 0));
      end
    end else begin
      if (kind == 8) begin
        len = $urandom_range(1, 14);
      end else if ($urandom_range(0, 5) == 0) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(21, 40) : $urandom_range(16, 20);
      end else begin
        len = 15;
      end
      for (int i = 0; i < len; i++) begin
        if (i == 0) begin
          b = gprp_pkg::HDR_FIRST;
        end else if (i == 1) begin
          b = gprp_pkg::HDR_SECOND;
        end else if (i == 7 || i == 9 || i == 11 || i == 13) begin
          b = pick_axis(cur_dz);
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        bytes.push_back(b);
      end
      if (kind == 7) begin
        if ($urandom_range(0, 1) == 0) begin
          bytes[0] = 8'($urandom_range(1, 255));
        end else begin
          do bytes[1] = 8'($urandom_range(0, 255)); while (bytes[1] == gprp_pkg::HDR_SECOND);
        end
      end
      send_report(bytes);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (IdleCycles) @(posedge clk_i);
  endtask

  task automatic write_deadzone(input logic [6:0] dz);
    cfg_valid_i    <= 1'b1;
    cfg_deadzone_i <= dz;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_dz = int'(dz);
  endtask

  initial begin : stimulus
    logic [7:0] extreme [$];
    logic [6:0] dz_plan [$];
    int         waited;
    bytes_sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full-scale sticks, left Y at -128 and right Y at +127, a diagonal on the pad,
    // then a short report and a lone final byte.
    extreme = '{gprp_pkg::HDR_FIRST, gprp_pkg::HDR_SECOND, 8'hF8, 8'hFF, 8'h00, 8'hFF,
                8'h00, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'h80, 8'h00, 8'h7F, 8'h55};
    send_report(extreme);
    send_report('{gprp_pkg::HDR_FIRST, gprp_pkg::HDR_SECOND});
    send_report('{gprp_pkg::HDR_SECOND});
    wait_idle();

    dz_plan = '{7'd0, 7'd127, 7'd126, 7'd1, 7'd0, 7'd0, gprp_pkg::DEADZONE_RESET};
    dz_plan[4] = 7'($urandom_range(2, 125));
    dz_plan[5] = 7'($urandom_range(2, 125));
    for (int ph = 0; ph < PhaseCount; ph++) begin
      write_deadzone(dz_plan[ph]);
      if (ph == 2) begin
        hold_req <= 1'b1;
      end
      if (ph == PhaseCount - 1) begin
        quiet <= 1'b1;
      end
      bytes_sent = 0;
      while (bytes_sent < PhaseBytes) begin
        send_random_report();
      end
      if (ph != PhaseCount - 1) begin
        wait_idle();
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    waited = 0;
    while (pending != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (IdleCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("gamepad_report_parser_core_tb passed");
    end else begin
      $display("gamepad_report_parser_core_tb failed");
    end
    $finish;
  end

endmodule
